### rtl/kdt_pkg.sv
package kdt_pkg;

	localparam int unsigned DEBOUNCE_DEPTH_DEF = 5;
	localparam int unsigned FRAME_W = 64;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned NUM_KEYS = 35;
	localparam int unsigned KEY_IDX_W = $clog2(NUM_KEYS);

	localparam int unsigned KEY_SHIFT_BIT = 5;
	localparam int unsigned KEY_UP_BIT = 1;
	localparam int unsigned KEY_DOWN_BIT = 2;
	localparam int unsigned KEY_ON_BIT = 63;

	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	typedef enum logic [1:0] {
		MAP_BASE  = 2'd0,
		MAP_CAPS  = 2'd1,
		MAP_SHIFT = 2'd2
	} map_t;

	// lock and shift state seen by the translator
	typedef struct packed {
		logic shift;
		logic num;
		logic caps;
	} mode_t;

	localparam logic [5:0] KEY_BIT [NUM_KEYS] = '{
		6'(KEY_ON_BIT), 6'd1, 6'd2, 6'd3, 6'd4,
		6'd9, 6'd14, 6'd19, 6'd34, 6'd24, 6'd29, 6'd8, 6'd13, 6'd18, 6'd33, 6'd23, 6'd28,
		6'd7, 6'd12, 6'd17, 6'd32, 6'd22, 6'd27, 6'd6, 6'd11, 6'd16, 6'd31, 6'd21, 6'd26,
		6'd15, 6'd30, 6'd25, 6'd20, 6'd0, 6'd10
	};

	localparam char_t CHAR_BASE [NUM_KEYS] = '{
		8'd1, 8'd3, 8'd4, 8'd5, 8'd6,
		"A", "B", "C", "D", "E", "F", "G", "H", "I", "J", "K", "L", "M",
		"N", "O", "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
		8'd13, " ", 8'd2, 8'd8
	};

	localparam char_t CHAR_CAPS [NUM_KEYS] = '{
		8'd1, 8'd3, 8'd4, 8'd5, 8'd6,
		"a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "l", "m",
		"n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z",
		8'd13, " ", 8'd2, 8'd7
	};

	localparam char_t CHAR_SHIFT [NUM_KEYS] = '{
		8'd1, 8'd3, 8'd4, 8'd5, 8'd6,
		"<", ">", "(", ")", "%", "/", "=", 8'h22, "7", "8", "9", "*", ",",
		"$", "4", "5", "6", "-", ";", ":", "1", "2", "3", "+", "0", ".",
		8'd13, " ", 8'd2, 8'd7
	};

	// shift selects the shifted map only while num lock is clear
	function automatic map_t mode_map(input mode_t m);
		map_t r;
		case ({m.shift, m.num, m.caps})
			3'b001:  r = MAP_CAPS;
			3'b010,
			3'b011,
			3'b100,
			3'b101:  r = MAP_SHIFT;
			default: r = MAP_BASE;
		endcase
		return r;
	endfunction

endpackage

### rtl/kdt_scan_if.sv
interface kdt_scan_if;
	logic valid;
	logic ready;
	logic [kdt_pkg::FRAME_W-1:0] matrix_frame;
	logic ext_valid;
	logic [kdt_pkg::CHAR_W-1:0] ext_code;

	modport source(output valid, matrix_frame, ext_valid, ext_code, input ready);
	modport sink(input valid, matrix_frame, ext_valid, ext_code, output ready);
endinterface

### rtl/kdt_keys_if.sv
interface kdt_keys_if;
	logic valid;
	logic ready;
	logic key_valid;
	logic [kdt_pkg::CHAR_W-1:0] key_char;
	logic ext_busy;
	logic caps_lock;
	logic num_lock;

	modport source(output valid, key_valid, key_char, ext_busy, caps_lock, num_lock,
		input ready);
	modport sink(input valid, key_valid, key_char, ext_busy, caps_lock, num_lock,
		output ready);
endinterface

### rtl/kdt_xlate.sv
module kdt_xlate (
	input  kdt_pkg::frame_t press,
	input  kdt_pkg::mode_t  mode,
	output logic            hit,
	output kdt_pkg::char_t  key_char
);

	kdt_pkg::key_idx_t idx;
	kdt_pkg::map_t     map;

	// priority pick: lowest map position wins, so scan from the top down
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int k = kdt_pkg::NUM_KEYS - 1; k >= 0; k--) begin
			if (press[kdt_pkg::KEY_BIT[k]]) begin
				hit = 1'b1;
				idx = kdt_pkg::KEY_IDX_W'(k);
			end
		end
	end

	assign map = kdt_pkg::mode_map(mode);

	always_comb begin
		case (map)
			kdt_pkg::MAP_CAPS:  key_char = kdt_pkg::CHAR_CAPS[idx];
			kdt_pkg::MAP_SHIFT: key_char = kdt_pkg::CHAR_SHIFT[idx];
			default:            key_char = kdt_pkg::CHAR_BASE[idx];
		endcase
	end

endmodule

### rtl/keyboard_debounce_translate_top.sv
// Keyboard matrix debouncer and character translator.
// scan channel: one request per scanned 64-bit key matrix frame, with an
// optional external key code (ext_valid, ext_code) to inject.
// keys channel: exactly one result per request: key_valid/key_char for the
// emitted character (key_char is 0 when nothing is emitted), ext_busy while
// an injected code is still waiting, and the caps and num lock states.
// A key is held once it is set in the last DEBOUNCE_DEPTH frames; its press
// edge emits a character from the base, caps or shifted map, first key in
// map order wins, and shift with up/down toggles caps/num lock.
// Throughput is one request per cycle while keys is ready; a request taken
// is loaded into the input register and then into the result register,
// which drives keys.
// The debounce and lock state are updated when a request moves from the
// input register to the result register, in request order.
// When keys stalls, the result register holds and the input register still
// takes one more request; scan.ready drops only when both are full.
// arst_n clears the frame history, held keys, lock states and pending
// external code, and empties both registers.
module keyboard_debounce_translate_top #(
	parameter int unsigned DEBOUNCE_DEPTH = kdt_pkg::DEBOUNCE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	kdt_scan_if.sink          scan,
	kdt_keys_if.source        keys
);

	localparam int unsigned HIST_N = DEBOUNCE_DEPTH - 1;

	logic              valid_s1;
	kdt_pkg::frame_t   frame_s1;
	logic              ext_valid_s1;
	kdt_pkg::char_t    ext_code_s1;

	logic              valid_s2;
	logic              key_valid_s2;
	kdt_pkg::char_t    key_char_s2;
	logic              ext_busy_s2;
	logic              caps_s2;
	logic              num_s2;

	kdt_pkg::frame_t   hist_q [HIST_N];
	kdt_pkg::frame_t   held_q;
	logic              caps_q;
	logic              num_q;
	logic              pend_q;
	kdt_pkg::char_t    pend_code_q;

	logic              take;
	logic              advance;
	kdt_pkg::frame_t   hist_and;
	kdt_pkg::frame_t   all_held;
	kdt_pkg::frame_t   press;
	logic              shift;
	logic              caps_n;
	logic              num_n;
	logic              pend_lat;
	kdt_pkg::char_t    pend_code_lat;
	kdt_pkg::mode_t    mode;
	logic              hit;
	kdt_pkg::char_t    hit_char;
	logic              kv;
	kdt_pkg::char_t    kc;
	logic              pend_n;

	assign advance    = valid_s1 && (!valid_s2 || keys.ready);
	assign scan.ready = !valid_s1 || advance;
	assign take       = scan.valid && scan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1     <= scan.matrix_frame;
			ext_valid_s1 <= scan.ext_valid;
			ext_code_s1  <= scan.ext_code;
		end
	end

	always_comb begin
		hist_and = '1;
		for (int i = 0; i < HIST_N; i++) begin
			hist_and = hist_and & hist_q[i];
		end
	end

	assign all_held = frame_s1 & hist_and;
	assign press    = all_held & ~held_q;
	assign shift    = all_held[kdt_pkg::KEY_SHIFT_BIT];
	assign caps_n   = caps_q ^ (shift & press[kdt_pkg::KEY_UP_BIT]);
	assign num_n    = num_q ^ (shift & press[kdt_pkg::KEY_DOWN_BIT]);

	// a new offer is only latched into a free slot
	assign pend_lat      = pend_q | ext_valid_s1;
	assign pend_code_lat = pend_q ? pend_code_q : ext_code_s1;

	assign mode.shift = shift;
	assign mode.num   = num_n;
	assign mode.caps  = caps_n;

	kdt_xlate u_xlate (
		.press    (press),
		.mode     (mode),
		.hit      (hit),
		.key_char (hit_char)
	);

	// matrix key wins, the external code keeps waiting
	assign kv     = hit | pend_lat;
	assign kc     = hit ? hit_char : (pend_lat ? pend_code_lat : '0);
	assign pend_n = pend_lat & hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
			held_q      <= '0;
			caps_q      <= 1'b0;
			num_q       <= 1'b0;
			pend_q      <= 1'b0;
			pend_code_q <= '0;
		end else if (advance) begin
			hist_q[0] <= frame_s1;
			for (int i = 1; i < HIST_N; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			held_q      <= all_held;
			caps_q      <= caps_n;
			num_q       <= num_n;
			pend_q      <= pend_n;
			pend_code_q <= pend_code_lat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (keys.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_valid_s2 <= kv;
			key_char_s2  <= kc;
			ext_busy_s2  <= pend_n;
			caps_s2      <= caps_n;
			num_s2       <= num_n;
		end
	end

	assign keys.valid     = valid_s2;
	assign keys.key_valid = key_valid_s2;
	assign keys.key_char  = key_char_s2;
	assign keys.ext_busy  = ext_busy_s2;
	assign keys.caps_lock = caps_s2;
	assign keys.num_lock  = num_s2;

	// no character means a zero code
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !key_valid_s2 |-> key_char_s2 == '0)
		else $error("key_char nonzero without key_valid");

	// a waiting external code goes out on the first frame with no press
	a_pend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pend_q && !hit |=> !pend_q)
		else $error("pending external code not emitted");

	// debounce and lock state only move with a request
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(held_q) && $stable(caps_q) && $stable(num_q))
		else $error("state changed without a request");

	// result register mirrors the lock state it was built from
	a_lock_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> caps_s2 == caps_q && num_s2 == num_q && ext_busy_s2 == pend_q)
		else $error("result lock state differs from stored state");

	// a stalled input register keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(frame_s1))
		else $error("input register lost a stalled request");

endmodule
